// ===== rtl/core/hlc_pkg.sv =====
// ----------------------------------------------------------------------------
// hlc_pkg
// Shared widths and constants for the homogeneous line clipper.
// ----------------------------------------------------------------------------
package hlc_pkg;

	localparam int CoordBits = 32;
	localparam int FracBits  = 16;
	localparam int TFrac     = 16;
	localparam int DistBits  = CoordBits + 2;
	localparam int NumPlanes = 6;

	typedef logic signed [CoordBits-1:0] coord_t;
	typedef logic signed [DistBits-1:0]  dist_t;
	typedef logic [TFrac:0]              tpar_t;

	localparam tpar_t  TOne    = tpar_t'(1) << TFrac;
	localparam coord_t RejXyz  = coord_t'(2) << FracBits;
	localparam coord_t RejW    = coord_t'(1) << FracBits;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		coord_t w;
	} vec_t;

	function automatic dist_t plane_dist(input vec_t p, input int k);
		dist_t x, y, z, w, r;
		x = dist_t'(p.x);
		y = dist_t'(p.y);
		z = dist_t'(p.z);
		w = dist_t'(p.w);
		case (k)
			0: r = w + x;
			1: r = w - x;
			2: r = w + y;
			3: r = w - y;
			4: r = z;
			default: r = w - z;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/core/hlc_div.sv =====
// ----------------------------------------------------------------------------
// hlc_div
// Pipelined restoring divider: clamped crossing parameter num/den in
// [0,1] with TFrac fraction bits. One quotient bit per stage.
// ----------------------------------------------------------------------------
module hlc_div
	import hlc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [DistBits:0]    num,
	input  logic [DistBits:0]    den,
	input  logic                 zero,
	output tpar_t                t
);
	localparam int W = DistBits + 1;

	logic [W:0]       n_q [TFrac+1];
	logic [W-1:0]     d_q [TFrac+1];
	logic [TFrac-1:0] qb_q [TFrac+1];
	logic             sat_q [TFrac+1];
	logic             z_q [TFrac+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= TFrac; i++) begin
				sat_q[i] <= 1'b0;
			end
		end else if (en) begin
			sat_q[0] <= zero || (num >= den);
			for (int i = 1; i <= TFrac; i++) begin
				sat_q[i] <= sat_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_q[0]  <= {1'b0, num};
			d_q[0]  <= den;
			qb_q[0] <= '0;
			for (int i = 1; i <= TFrac; i++) begin
				d_q[i] <= d_q[i-1];
				if ({n_q[i-1][W-1:0], 1'b0} >= {1'b0, d_q[i-1]}) begin
					n_q[i]  <= {n_q[i-1][W-1:0], 1'b0} - {1'b0, d_q[i-1]};
					qb_q[i] <= {qb_q[i-1][TFrac-2:0], 1'b1};
				end else begin
					n_q[i]  <= {n_q[i-1][W-1:0], 1'b0};
					qb_q[i] <= {qb_q[i-1][TFrac-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_q[0] <= zero;
			for (int i = 1; i <= TFrac; i++) begin
				z_q[i] <= z_q[i-1];
			end
		end
	end

	assign t = sat_q[TFrac] ? (z_q[TFrac] ? '0 : TOne) : {1'b0, qb_q[TFrac]};

endmodule

// ===== rtl/core/hlc_lerp.sv =====
// ----------------------------------------------------------------------------
// hlc_lerp
// Two-stage interpolation a + trunc((b-a)*t), product toward zero.
// ----------------------------------------------------------------------------
module hlc_lerp
	import hlc_pkg::*;
(
	input  logic   clk,
	input  logic   en,
	input  coord_t a,
	input  coord_t b,
	input  tpar_t  t,
	output coord_t p
);
	logic signed [CoordBits:0] diff;
	logic [CoordBits:0]        m;
	logic [CoordBits+TFrac:0]  prod_s1;
	logic                      neg_s1;
	coord_t                    a_s1;
	coord_t                    p_s2;

	assign diff = {b[CoordBits-1], b} - {a[CoordBits-1], a};
	assign m    = diff[CoordBits] ? -diff : diff;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (CoordBits+TFrac+1)'(m) * (CoordBits+TFrac+1)'(t);
			neg_s1  <= diff[CoordBits];
			a_s1    <= a;
			p_s2    <= neg_s1 ? a_s1 - coord_t'(prod_s1 >> TFrac)
			                  : a_s1 + coord_t'(prod_s1 >> TFrac);
		end
	end

	assign p = p_s2;

endmodule

// ===== rtl/core/homogeneous_line_clipper.sv =====
// ----------------------------------------------------------------------------
// homogeneous_line_clipper
// Clips a homogeneous segment against the six clip planes.
// ----------------------------------------------------------------------------
// Fully pipelined: one segment per cycle, busy is always low. A result
// appears with done high after start; the latency is set by the crossing
// dividers feeding the interpolation multipliers.
// The receiver cannot stall and the pipeline never stalls.
module homogeneous_line_clipper
	import hlc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  coord_t a_x, a_y, a_z, a_w,
	input  coord_t b_x, b_y, b_z, b_w,
	output logic   done,
	output logic   visible,
	output coord_t out_a_x, out_a_y, out_a_z, out_a_w,
	output coord_t out_b_x, out_b_y, out_b_z, out_b_w
);
	localparam int Lat = TFrac + 5;
	localparam int DW  = DistBits + 1;

	logic   en;
	vec_t   pa, pb;
	logic   v_s [Lat+1];

	assign busy = 1'b0;
	assign en   = 1'b1;
	assign pa = '{x: a_x, y: a_y, z: a_z, w: a_w};
	assign pb = '{x: b_x, y: b_y, z: b_z, w: b_w};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= Lat; i++) v_s[i] <= 1'b0;
		end else begin
			v_s[0] <= start;
			for (int i = 1; i <= Lat; i++) v_s[i] <= v_s[i-1];
		end
	end

	// stage 1: distances, classification, divider operands
	logic [NumPlanes-1:0] ina_s1, inb_s1, rej_s1, zer_s1;
	logic [DW-1:0]        num_s1 [NumPlanes];
	logic [DW-1:0]        den_s1 [NumPlanes];
	vec_t                 pa_s1, pb_s1;

	always_ff @(posedge clk) begin
		for (int k = 0; k < NumPlanes; k++) begin
			logic signed [DW-1:0] d0, d1, nm, dn;
			logic ia, ib;
			d0 = DW'(plane_dist(pa, k));
			d1 = DW'(plane_dist(pb, k));
			ia = d0 >= 1;
			ib = d1 >= 1;
			nm = 1 - d0;
			dn = d1 - d0;
			ina_s1[k] <= ia;
			inb_s1[k] <= ib;
			rej_s1[k] <= (!ia && !ib) || (ia != ib && dn == 0);
			zer_s1[k] <= nm == 0 || (nm < 0) != (dn < 0);
			num_s1[k] <= nm < 0 ? -nm : nm;
			den_s1[k] <= dn < 0 ? -dn : dn;
		end
		pa_s1 <= pa;
		pb_s1 <= pb;
	end

	tpar_t tk [NumPlanes];
	for (genvar k = 0; k < NumPlanes; k++) begin : g_div
		hlc_div u_div (
			.clk(clk), .arst_n(arst_n), .en(en),
			.num(num_s1[k]), .den(den_s1[k]), .zero(zer_s1[k]), .t(tk[k])
		);
	end

	// delay classification and endpoints past the divider
	logic [NumPlanes-1:0] ina_d [TFrac+1], act_d [TFrac+1];
	logic                 rj_d  [TFrac+1];
	vec_t                 pa_d  [TFrac+2], pb_d [TFrac+2];
	always_ff @(posedge clk) begin
		ina_d[0] <= ina_s1;
		act_d[0] <= ~(ina_s1 & inb_s1);
		rj_d[0]  <= |rej_s1;
		pa_d[0]  <= pa_s1;
		pb_d[0]  <= pb_s1;
		for (int i = 1; i <= TFrac; i++) begin
			ina_d[i] <= ina_d[i-1];
			act_d[i] <= act_d[i-1];
			rj_d[i]  <= rj_d[i-1];
			pa_d[i]  <= pa_d[i-1];
			pb_d[i]  <= pb_d[i-1];
		end
		pa_d[TFrac+1] <= pa_d[TFrac];
		pb_d[TFrac+1] <= pb_d[TFrac];
	end

	// stage: interval fold (six narrow compares)
	tpar_t tlo_c, thi_c;
	logic  keep_c;
	always_comb begin
		tlo_c  = '0;
		thi_c  = TOne;
		keep_c = !rj_d[TFrac];
		for (int k = 0; k < NumPlanes; k++) begin
			if (act_d[TFrac][k]) begin
				if (!ina_d[TFrac][k]) begin
					if (tk[k] > tlo_c) tlo_c = tk[k];
				end else begin
					if (tk[k] < thi_c) thi_c = tk[k];
				end
			end
		end
		if (tlo_c > thi_c) keep_c = 1'b0;
	end
	// The earlier-plane early exit only matters for rejection; the fold
	// of all planes gives the same keep outcome and same t where kept.

	tpar_t tlo_s3, thi_s3;
	logic  keep_s3;
	always_ff @(posedge clk) begin
		tlo_s3  <= tlo_c;
		thi_s3  <= thi_c;
		keep_s3 <= keep_c;
	end

	coord_t ra [4], rb [4];
	coord_t ca [4], cb [4];
	assign ca = '{pa_d[TFrac+1].x, pa_d[TFrac+1].y, pa_d[TFrac+1].z, pa_d[TFrac+1].w};
	assign cb = '{pb_d[TFrac+1].x, pb_d[TFrac+1].y, pb_d[TFrac+1].z, pb_d[TFrac+1].w};
	for (genvar c = 0; c < 4; c++) begin : g_lerp
		hlc_lerp u_la (.clk(clk), .en(en), .a(ca[c]), .b(cb[c]), .t(tlo_s3), .p(ra[c]));
		hlc_lerp u_lb (.clk(clk), .en(en), .a(ca[c]), .b(cb[c]), .t(thi_s3), .p(rb[c]));
	end

	logic keep_s4, keep_s5;
	always_ff @(posedge clk) begin
		keep_s4 <= keep_s3;
		keep_s5 <= keep_s4;
	end

	logic   vis_q;
	coord_t oa_q [4], ob_q [4];
	always_ff @(posedge clk) begin
		vis_q <= keep_s5 && ra[3] > 0 && rb[3] > 0;
		for (int c = 0; c < 4; c++) begin
			if (keep_s5 && ra[3] > 0 && rb[3] > 0) begin
				oa_q[c] <= ra[c];
				ob_q[c] <= rb[c];
			end else begin
				oa_q[c] <= (c == 3) ? RejW : RejXyz;
				ob_q[c] <= (c == 3) ? RejW : RejXyz;
			end
		end
	end

	assign done    = v_s[Lat];
	assign visible = vis_q;
	assign out_a_x = oa_q[0];
	assign out_a_y = oa_q[1];
	assign out_a_z = oa_q[2];
	assign out_a_w = oa_q[3];
	assign out_b_x = ob_q[0];
	assign out_b_y = ob_q[1];
	assign out_b_z = ob_q[2];
	assign out_b_w = ob_q[3];

	a_busy_low: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(v_s[Lat-1]))
		else $error("done latency");
	a_vis_rej: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !visible) |-> out_a_w == RejW && out_b_w == RejW)
		else $error("rejected w");
	a_vis_w: assert property (@(posedge clk) disable iff (!arst_n)
		(done && visible) |-> out_a_w > 0 && out_b_w > 0)
		else $error("visible w");

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the homogeneous line clipper: directed and random
// segments are sent under varying idle patterns, a local clip predictor
// queues the expected endpoints, and each done strobe is checked in order.
// ----------------------------------------------------------------------------
module tb;
	import hlc_pkg::*;

	localparam int Latency  = 21;
	localparam int MaxCycle = 400000;

	typedef struct {
		logic   vis;
		coord_t ra[4];
		coord_t rb[4];
	} clip_res_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   start = 1'b0;
	logic   busy, done, visible;
	coord_t a_x = '0, a_y = '0, a_z = '0, a_w = '0;
	coord_t b_x = '0, b_y = '0, b_z = '0, b_w = '0;
	coord_t out_a_x, out_a_y, out_a_z, out_a_w;
	coord_t out_b_x, out_b_y, out_b_z, out_b_w;

	clip_res_t clip_q[$];
	int  idle_pct = 0;
	int  n_err = 0;
	int  cyc = 0;

	homogeneous_line_clipper dut (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > MaxCycle) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic signed [63:0] pdist(logic signed [63:0] p[4], int k);
		case (k)
			0: return p[3] + p[0];
			1: return p[3] - p[0];
			2: return p[3] + p[1];
			3: return p[3] - p[1];
			4: return p[2];
			default: return p[3] - p[2];
		endcase
	endfunction

	function automatic logic [16:0] tcross(logic signed [63:0] num, logic signed [63:0] den);
		logic [63:0] n, d;
		logic [16:0] q;
		q = '0;
		if (num == 0 || ((num < 0) != (den < 0))) return '0;
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		if (n >= d) return TOne;
		for (int i = 0; i < TFrac; i++) begin
			n = n << 1;
			q = q << 1;
			if (n >= d) begin
				n = n - d;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic signed [63:0] lerp(logic signed [63:0] a, logic signed [63:0] b,
			logic [16:0] t);
		logic signed [63:0] df;
		logic [63:0] m, pr;
		df = b - a;
		m = df < 0 ? -df : df;
		pr = (m >> TFrac) * t + (((m & 64'hffff) * t) >> TFrac);
		return df < 0 ? a - $signed(pr) : a + $signed(pr);
	endfunction

	function automatic clip_res_t predict_clip(coord_t av[4], coord_t bv[4]);
		logic signed [63:0] pa[4], pb[4], ra[4], rb[4];
		logic signed [63:0] d0, d1, den;
		logic [16:0] tlo, thi, t;
		logic keep;
		clip_res_t r;
		tlo = '0;
		thi = TOne;
		keep = 1'b1;
		for (int k = 0; k < 4; k++) begin
			pa[k] = av[k];
			pb[k] = bv[k];
		end
		for (int k = 0; k < NumPlanes && keep; k++) begin
			d0 = pdist(pa, k);
			d1 = pdist(pb, k);
			if (d0 >= 1 && d1 >= 1) continue;
			if (d0 < 1 && d1 < 1) begin
				keep = 1'b0;
				break;
			end
			den = d1 - d0;
			if (den == 0) begin
				keep = 1'b0;
				break;
			end
			t = tcross(1 - d0, den);
			if (d0 < 1) begin
				if (t > tlo) tlo = t;
			end else if (t < thi) thi = t;
			if (tlo > thi) keep = 1'b0;
		end
		if (keep) begin
			for (int k = 0; k < 4; k++) begin
				ra[k] = lerp(pa[k], pb[k], tlo);
				rb[k] = lerp(pa[k], pb[k], thi);
			end
			if (ra[3] <= 0 || rb[3] <= 0) keep = 1'b0;
		end
		r.vis = keep;
		for (int k = 0; k < 4; k++) begin
			r.ra[k] = keep ? coord_t'(ra[k]) : (k == 3 ? RejW : RejXyz);
			r.rb[k] = keep ? coord_t'(rb[k]) : (k == 3 ? RejW : RejXyz);
		end
		return r;
	endfunction

	task automatic chk(string nm, coord_t e, coord_t a);
		if (e !== a) begin
			$error("%s expected %0d got %0d", nm, e, a);
			n_err++;
		end
	endtask

	always @(posedge clk) begin
		clip_res_t e;
		if (arst_n && done) begin
			if (clip_q.size() == 0) begin
				$error("result with no request pending");
				n_err++;
			end else begin
				e = clip_q.pop_front();
				if (e.vis !== visible) begin
					$error("visible expected %0d got %0d", e.vis, visible);
					n_err++;
				end
				chk("out_a_x", e.ra[0], out_a_x);
				chk("out_a_y", e.ra[1], out_a_y);
				chk("out_a_z", e.ra[2], out_a_z);
				chk("out_a_w", e.ra[3], out_a_w);
				chk("out_b_x", e.rb[0], out_b_x);
				chk("out_b_y", e.rb[1], out_b_y);
				chk("out_b_z", e.rb[2], out_b_z);
				chk("out_b_w", e.rb[3], out_b_w);
			end
		end
	end

	task automatic send_segment(coord_t av[4], coord_t bv[4]);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		{a_x, a_y, a_z, a_w} <= {av[0], av[1], av[2], av[3]};
		{b_x, b_y, b_z, b_w} <= {bv[0], bv[1], bv[2], bv[3]};
		@(posedge clk);
		while (busy) @(posedge clk);
		clip_q.insert(clip_q.size(), predict_clip(av, bv));
	endtask

	function automatic coord_t rcoord(int mode);
		case (mode)
			0: return $urandom;
			1: return coord_t'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
			default: return coord_t'($signed($urandom_range(0, 4 << 16)));
		endcase
	endfunction

	task automatic test_directed();
		coord_t ext[6] = '{32'sh7fffffff, 32'sh80000000, 0, 1, -1, 32'sh10000};
		coord_t av[4], bv[4];
		for (int i = 0; i < 6; i++) begin
			for (int k = 0; k < 4; k++) begin
				av[k] = ext[i];
				bv[k] = ext[(i + k + 1) % 6];
			end
			send_segment(av, bv);
		end
		av = '{0, 0, 32'sh8000, 32'sh10000};
		bv = '{32'sh8000, 32'sh8000, 32'sh8000, 32'sh10000};
		send_segment(av, bv);
		bv = '{32'sh30000, 0, 32'sh8000, 32'sh10000};
		send_segment(av, bv);
		send_segment(bv, av);
		av = '{32'sh30000, 0, 32'sh8000, 32'sh10000};
		bv = '{32'sh40000, 0, 32'sh8000, 32'sh10000};
		send_segment(av, bv);
		av = '{32'sh30000, 0, 32'sh8000, 32'sh10000};
		bv = '{0, 32'sh30000, 32'sh8000, 32'sh10000};
		send_segment(av, bv);
		av = '{0, 0, 32'sh8000, 32'sh10000};
		bv = '{0, 0, 32'sh8000, -32'sh10000};
		send_segment(av, bv);
		bv = '{0, 0, -32'sh10000, 32'sh10000};
		send_segment(av, bv);
		av = '{0, 0, 0, 1};
		bv = '{0, 0, 0, 1};
		send_segment(av, bv);
		av = '{1, 0, 0, 0};
		send_segment(av, bv);
	endtask

	task automatic test_random(int n);
		coord_t av[4], bv[4];
		int mode;
		for (int i = 0; i < n; i++) begin
			mode = $urandom_range(9) < 2 ? 0 : ($urandom_range(1) ? 1 : 2);
			for (int k = 0; k < 4; k++) begin
				av[k] = rcoord(k == 3 && mode != 0 ? 2 : mode);
				bv[k] = rcoord(k == 3 && mode != 0 ? 2 : mode);
			end
			send_segment(av, bv);
		end
	endtask

	initial begin
		int w;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		idle_pct = 0;
		test_random(500);
		idle_pct = 63;
		test_random(400);
		idle_pct = 34;
		test_random(300);
		idle_pct = 0;
		test_random(300);
		start <= 1'b0;
		w = 0;
		while (clip_q.size() != 0 && w < 1000) begin
			@(posedge clk);
			w++;
		end
		repeat (Latency + 5) @(posedge clk);
		if (n_err == 0 && clip_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

// ===== homogeneous_line_clipper.f =====
rtl/core/hlc_pkg.sv
rtl/core/hlc_div.sv
rtl/core/hlc_lerp.sv
rtl/core/homogeneous_line_clipper.sv
test/tb.sv
